### rtl/core/stlw_pkg.sv
// ----------------------------------------------------------------------------
// stlw_pkg
// Shared types, register codes and the sigmoid table of the soft tree leaf
// weight block.
// ----------------------------------------------------------------------------
package stlw_pkg;

  // sizes
  localparam int MaxDims    = 4;
  localparam int SigEntries = 256;
  localparam int SigW       = $clog2(SigEntries);
  localparam int DimW       = 2;
  localparam int ValW       = 16;
  localparam int CfgIdxW    = 3;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 40;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegSharpness = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumDims   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLeaf0     = 3'd2;

  // fixed-point constants
  localparam logic [ValW-1:0] ProbOne    = 16'd32768;
  localparam logic [ValW-1:0] SharpReset = 16'd256;
  localparam logic [63:0]     OneQ30     = 64'd1 << 30;

  // command from the controller to the datapath
  typedef struct packed {
    logic load;     // capture input item, lambda multiply
    logic look;     // sigmoid table read
    logic upd;      // running product update
    logic calc;     // contribution of the current dimension
    logic advance;  // step to the next dimension
    logic finish;   // leaf done, probability back to one
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_split;
    logic last_dim;
  } status_t;

  typedef logic [ValW-1:0] sig_tab_t [SigEntries];

  // restoring division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-r) in Q30 for r in [0,1], series with 25 terms
  function automatic logic [63:0] exp_frac(input logic [63:0] r);
    logic signed [63:0] sum;
    logic [63:0] term;
    logic [63:0] prod;
    int k;
    sum  = signed'(OneQ30);
    term = OneQ30;
    for (k = 1; k <= 24; k++) begin
      prod = term * r;
      term = udiv64(prod >> 30, 64'(k));
      if (k % 2 == 1) sum = sum - signed'(term);
      else            sum = sum + signed'(term);
    end
    return (sum < 0) ? 64'd0 : unsigned'(sum);
  endfunction

  // exp(-a) in Q30 for a in [0,8]
  function automatic logic [63:0] exp_neg(input logic [63:0] a);
    logic [63:0] e1;
    logic [63:0] n;
    logic [63:0] e;
    int i;
    e1 = exp_frac(OneQ30);
    n  = a >> 30;
    e  = exp_frac(a & (OneQ30 - 64'd1));
    for (i = 0; i < 16; i++) begin
      if (64'(i) < n) e = (e * e1) >> 30;
    end
    return e;
  endfunction

  // sigmoid at the bin centers in Q1.15
  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    logic [63:0] n;
    logic [63:0] c;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] val;
    logic pos;
    int i;
    n = 64'(SigEntries);
    for (i = 0; i < SigEntries; i++) begin
      c      = 64'(2 * i + 1);
      pos    = (c > n);
      mag    = pos ? c - n : n - c;
      a      = udiv64((mag * 64'd8) << 30, n);
      e      = exp_neg(a);
      den    = OneQ30 + e;
      num    = pos ? 64'd32768 * OneQ30 : 64'd32768 * e;
      val    = udiv64(64'd2 * num + den, 64'd2 * den);
      tab[i] = val[ValW-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTable = build_sig_table();

endpackage

### rtl/core/stlw_ctrl.sv
// ----------------------------------------------------------------------------
// stlw_ctrl
// Sequencer of the soft tree leaf weight block: steps each item through the
// lambda multiply, table read and product update; a last split emits the leaf.
// ----------------------------------------------------------------------------
module stlw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  stlw_pkg::status_t status_i,
  output stlw_pkg::cmd_t    cmd_o
);
  import stlw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_CALC,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // handshake and commands
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.look    = (state_q == ST_LOOK);
  assign cmd_o.upd     = (state_q == ST_UPD);
  assign cmd_o.calc    = (state_q == ST_CALC);
  assign cmd_o.advance = (state_q == ST_SEND) && out_ready_i && !status_i.last_dim;
  assign cmd_o.finish  = (state_q == ST_SEND) && out_ready_i && status_i.last_dim;

  // state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (status_i.last_split) state_q <= ST_CALC;
          else                     state_q <= ST_IDLE;
        end
        ST_CALC: begin
          state_q     <= ST_SEND;
          out_valid_q <= 1'b1;
        end
        ST_SEND: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (status_i.last_dim) state_q <= ST_IDLE;
            else                   state_q <= ST_CALC;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/core/stlw_dp.sv
// ----------------------------------------------------------------------------
// stlw_dp
// Datapath of the soft tree leaf weight block: configuration registers,
// lambda multiply, sigmoid table, running product and contribution multiply.
// ----------------------------------------------------------------------------
module stlw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stlw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stlw_pkg::ValW-1:0]     cfg_wdata_i,
  input  logic [stlw_pkg::InDataW-1:0]  in_data_i,
  input  logic                          in_last_i,
  input  stlw_pkg::cmd_t                cmd_i,
  output stlw_pkg::status_t             status_o,
  output logic [stlw_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_last_o
);
  import stlw_pkg::*;

  localparam logic signed [33:0] ArgLow  = -34'sd524288;
  localparam logic signed [33:0] ArgHigh = 34'sd524288;
  localparam logic [SigW:0]      SigEntriesL = (SigW+1)'(SigEntries);
  localparam logic [SigW:0]      SigLastL    = (SigW+1)'(SigEntries - 1);
  localparam logic [2:0]         MaxDimsL    = 3'(MaxDims);

  // configuration
  logic [ValW-1:0]        sharp_q;
  logic [2:0]             num_dims_q;
  logic signed [ValW-1:0] leaf_q [MaxDims];

  // per item and per leaf state
  logic [ValW-1:0]        prob_q;
  logic [DimW-1:0]        k_q;
  logic signed [33:0]     arg_q;
  logic [ValW-1:0]        sig_q;
  logic                   last_split_q;

  // output register
  logic [DimW-1:0]        dim_q;
  logic [ValW-1:0]        contr_q;
  logic [ValW-1:0]        oprob_q;
  logic                   olast_q;

  logic signed [16:0]     diff;
  logic signed [33:0]     arg_d;
  logic [19:0]            arg_off;
  logic [20+SigW:0]       idx_prod;
  logic [SigW:0]          idx_ext;
  logic [SigW-1:0]        idx;
  logic [32:0]            upd_sum;
  logic [DimW-1:0]        dims_m1;
  logic signed [32:0]     contr_sum;

  // lambda times feature minus threshold
  assign diff  = 17'(signed'(in_data_i[15:0])) - 17'(signed'(in_data_i[31:16]));
  assign arg_d = signed'({1'b0, sharp_q}) * diff;

  // table index: clamp to [-8,8) and scale into the bins
  assign arg_off  = arg_q[19:0] + 20'd524288;
  assign idx_prod = {{(SigW+1){1'b0}}, arg_off} * {20'd0, SigEntriesL};
  assign idx_ext  = idx_prod[20+SigW:20];
  always_comb begin
    priority if (arg_q < ArgLow)         idx = '0;
    else if (arg_q >= ArgHigh)           idx = SigLastL[SigW-1:0];
    else if (idx_ext >= SigEntriesL)     idx = SigLastL[SigW-1:0];
    else                                 idx = idx_ext[SigW-1:0];
  end

  // rounded product update in Q1.15
  assign upd_sum = 33'(prob_q) * 33'(sig_q) + 33'd16384;

  // effective dimension count minus one
  always_comb begin
    priority if (num_dims_q == 3'd0)    dims_m1 = '0;
    else if (num_dims_q > MaxDimsL)     dims_m1 = DimW'(MaxDims - 1);
    else                                dims_m1 = DimW'(num_dims_q - 3'd1);
  end

  // contribution of dimension k, rounded to Q8.8
  assign contr_sum = signed'({1'b0, prob_q}) * leaf_q[k_q] + 33'sd16384;

  assign status_o.last_split = last_split_q;
  assign status_o.last_dim   = (k_q == dims_m1);

  assign out_data_o = {6'd0, oprob_q, contr_q, dim_q};
  assign out_last_o = olast_q;

  // configuration and leaf state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sharp_q    <= SharpReset;
      num_dims_q <= 3'd1;
      for (int j = 0; j < MaxDims; j++) leaf_q[j] <= '0;
      prob_q     <= ProbOne;
      k_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSharpness) sharp_q    <= cfg_wdata_i;
        if (cfg_idx_i == RegNumDims)   num_dims_q <= cfg_wdata_i[2:0];
        for (int j = 0; j < MaxDims; j++) begin
          if (cfg_idx_i == CfgIdxW'(RegLeaf0 + CfgIdxW'(j))) leaf_q[j] <= cfg_wdata_i;
        end
      end
      if (cmd_i.upd) prob_q <= upd_sum[30:15];
      if (cmd_i.advance) k_q <= k_q + DimW'(1);
      if (cmd_i.finish) begin
        k_q    <= '0;
        prob_q <= ProbOne;
      end
    end
  end

  // pipeline and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arg_q        <= arg_d;
      last_split_q <= in_last_i;
    end
    if (cmd_i.look) sig_q <= SigTable[idx];
    if (cmd_i.calc) begin
      dim_q   <= k_q;
      contr_q <= contr_sum[30:15];
      oprob_q <= prob_q;
      olast_q <= (k_q == dims_m1);
    end
  end

endmodule

### rtl/core/soft_tree_leaf_weight_top.sv
// A split item runs through lambda multiply, table read and product update before the
// next item is accepted. On a last split the contribution of each dimension is then
// computed and offered in turn, the next one after the previous result is taken; the
// next item is accepted after the last result. Throughput is set by the sequencer running
// lambda multiply, table read and product multiply in turn on one item. Reset (rst_ni low,
// asynchronous) sets sharpness 256, one dimension, leaf values zero and the probability to one.
// ----------------------------------------------------------------------------
// soft_tree_leaf_weight_top
// Soft oblivious tree leaf weight: product of split sigmoids times leaf values.
// ----------------------------------------------------------------------------
module soft_tree_leaf_weight_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [stlw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stlw_pkg::ValW-1:0]     cfg_wdata_i,
  // split items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [stlw_pkg::InDataW-1:0]  s_axis_tdata,   // feature_value, threshold
  input  logic                          s_axis_tlast,   // last_split
  // leaf results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [stlw_pkg::OutDataW-1:0] m_axis_tdata,   // dim_index, contribution, probability
  output logic                          m_axis_tlast    // last_dim
);
  import stlw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  stlw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic
  stlw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### rtl/core/stlw_chk.sv
// ----------------------------------------------------------------------------
// stlw_chk
// Port-level checks of the soft tree leaf weight block, bound to the top level.
// ----------------------------------------------------------------------------
module stlw_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [stlw_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import stlw_pkg::*;

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // no new item while a result is offered
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while result pending");

  // probability never above one
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[33] && (m_axis_tdata[32:18] != 15'd0)))
    else $error("probability out of range");

  // busy right after an item is taken
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted in back-to-back cycles");

  // leaf stays open until its final result
  a_leaf_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input taken in the middle of a leaf");

endmodule

bind soft_tree_leaf_weight_top stlw_chk u_stlw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
